// ===== rtl/dsc_pkg.sv =====
// Package with payload types, character codes and parse phases for decimal_string_compare.
package dsc_pkg;

  localparam int MAX_DIGITS_DEF = 64;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic signed [1:0] ORD_LESS    = -2'sd1;
  localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
  localparam logic signed [1:0] ORD_GREATER = 2'sd1;

  typedef enum logic [4:0] {
    PH_BLANK = 5'b00001,
    PH_ZEROS = 5'b00010,
    PH_INT   = 5'b00100,
    PH_FRAC  = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       present;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [1:0] order;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic              cmp_int;
    logic              cmp_frac;
    logic              frac_in_range;
    logic [3:0]        digit;
    logic              res;
    logic              both_zero;
    logic              sign0;
    logic              sign1;
    logic signed [1:0] cnt_cmp;
    logic              tail_gt;
    logic              ovf;
  } stage_t;

endpackage

// ===== rtl/decimal_string_compare.sv =====
// Streaming numeric compare of two decimal strings.
//
//   channel | ports                       | moves
//   --------+-----------------------------+--------------------------------------
//   input   | in_valid, in_ready, in_data | one byte item per transfer
//   result  | out_valid, out_ready, out_data | order and overflow, one per pair
//
// One item is taken every cycle while in_ready is high. A result is valid once the
// second string's last item has passed the input register, the stored-digit read
// register and the result register.
// Reset clears all parse and control state; the digit stores need no clearing.
// The pipeline stalls only while a finished result waits and the next one is ready to leave.
module decimal_string_compare #(
  parameter int MAX_DIGITS = dsc_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dsc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dsc_pkg::out_t  out_data
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DIGITS);

  logic [3:0] int_mem [MAX_DIGITS];
  logic [3:0] frac_mem [MAX_DIGITS];

  logic              adv;
  logic              s1_valid_r;
  dsc_pkg::in_t      s1_r;
  logic              s2_valid_r;
  dsc_pkg::stage_t   s2_r;
  dsc_pkg::stage_t   s2_nxt;
  logic [3:0]        rd_int_r;
  logic [3:0]        rd_frac_r;
  logic              out_valid_r;
  dsc_pkg::out_t     out_r;
  dsc_pkg::out_t     out_nxt;

  dsc_pkg::phase_t   phase_r, phase_nxt;
  logic              on_second_r, on_second_nxt;
  logic              sign0_r, sign0_nxt, sign1_r, sign1_nxt;
  logic              hnz0_r, hnz0_nxt, hnz1_r, hnz1_nxt;
  logic [CW-1:0]     ic0_r, ic0_nxt, ic1_r, ic1_nxt;
  logic [CW-1:0]     fc0_r, fc0_nxt, fc1_r, fc1_nxt;
  logic [CW-1:0]     ffln_r, ffln_nxt;
  logic              ovf_r, ovf_nxt;
  logic signed [1:0] int_diff_r, int_diff_nxt;
  logic signed [1:0] frac_diff_r, frac_diff_nxt;

  logic [7:0]        c;
  logic [3:0]        d;
  logic              is_digit;
  logic              zeros_path;
  logic              take_int;
  logic              take_frac;
  logic [CW-1:0]     cur_ic;
  logic [CW-1:0]     cur_fc;
  logic              int_ok;
  logic              frac_ok;
  logic              wr_int;
  logic              wr_frac;
  logic [AW-1:0]     int_addr;
  logic [AW-1:0]     frac_addr;
  logic [3:0]        frac_a;
  logic signed [1:0] mag;
  logic signed [1:0] order;

  assign adv      = !(s2_valid_r && s2_r.res && out_valid_r && !out_ready);
  assign in_ready = adv;

  assign c        = s1_r.char_byte;
  assign d        = c[3:0];
  assign is_digit = (c >= dsc_pkg::CH_ZERO) && (c <= dsc_pkg::CH_NINE);
  assign cur_ic   = on_second_r ? ic1_r : ic0_r;
  assign cur_fc   = on_second_r ? fc1_r : fc0_r;
  assign int_ok   = cur_ic < CNT_MAX;
  assign frac_ok  = cur_fc < CNT_MAX;
  assign int_addr  = cur_ic[AW-1:0];
  assign frac_addr = cur_fc[AW-1:0];
  assign wr_int   = take_int && int_ok && !on_second_r;
  assign wr_frac  = take_frac && frac_ok && !on_second_r;

  always_comb begin
    phase_nxt     = phase_r;
    on_second_nxt = on_second_r;
    sign0_nxt     = sign0_r;
    sign1_nxt     = sign1_r;
    hnz0_nxt      = hnz0_r;
    hnz1_nxt      = hnz1_r;
    ic0_nxt       = ic0_r;
    ic1_nxt       = ic1_r;
    fc0_nxt       = fc0_r;
    fc1_nxt       = fc1_r;
    ffln_nxt      = ffln_r;
    ovf_nxt       = ovf_r;
    zeros_path    = 1'b0;
    take_int      = 1'b0;
    take_frac     = 1'b0;
    s2_nxt        = '0;
    s2_nxt.digit  = d;

    if (s1_valid_r && s1_r.present) begin
      case (phase_r)
        dsc_pkg::PH_BLANK: begin
          if (c == dsc_pkg::CH_SPACE || c == dsc_pkg::CH_TAB) begin
            phase_nxt = dsc_pkg::PH_BLANK;
          end else if (c == dsc_pkg::CH_MINUS || c == dsc_pkg::CH_PLUS) begin
            if (on_second_r) begin
              sign1_nxt = (c == dsc_pkg::CH_MINUS);
            end else begin
              sign0_nxt = (c == dsc_pkg::CH_MINUS);
            end
            phase_nxt = dsc_pkg::PH_ZEROS;
          end else begin
            zeros_path = 1'b1;
          end
        end
        dsc_pkg::PH_ZEROS: begin
          zeros_path = 1'b1;
        end
        dsc_pkg::PH_INT: begin
          if (is_digit) begin
            take_int = 1'b1;
          end else if (c == dsc_pkg::CH_POINT) begin
            phase_nxt = dsc_pkg::PH_FRAC;
          end else begin
            phase_nxt = dsc_pkg::PH_DONE;
          end
        end
        dsc_pkg::PH_FRAC: begin
          if (is_digit) begin
            take_frac = 1'b1;
          end else begin
            phase_nxt = dsc_pkg::PH_DONE;
          end
        end
        default: begin
          phase_nxt = dsc_pkg::PH_DONE;
        end
      endcase

      if (zeros_path) begin
        if (c == dsc_pkg::CH_ZERO) begin
          phase_nxt = dsc_pkg::PH_ZEROS;
        end else if (is_digit) begin
          take_int  = 1'b1;
          phase_nxt = dsc_pkg::PH_INT;
        end else if (c == dsc_pkg::CH_POINT) begin
          phase_nxt = dsc_pkg::PH_FRAC;
        end else begin
          phase_nxt = dsc_pkg::PH_DONE;
        end
      end
    end

    if (take_int) begin
      if (!int_ok) begin
        ovf_nxt = 1'b1;
      end else if (on_second_r) begin
        hnz1_nxt       = 1'b1;
        ic1_nxt        = ic1_r + 1'b1;
        s2_nxt.cmp_int = ic1_r < ic0_r;
      end else begin
        hnz0_nxt = 1'b1;
        ic0_nxt  = ic0_r + 1'b1;
      end
    end

    if (take_frac) begin
      if (!frac_ok) begin
        ovf_nxt = 1'b1;
      end else if (on_second_r) begin
        if (d != 4'd0) begin
          hnz1_nxt = 1'b1;
        end
        fc1_nxt              = fc1_r + 1'b1;
        s2_nxt.cmp_frac      = 1'b1;
        s2_nxt.frac_in_range = fc1_r < fc0_r;
      end else begin
        if (d != 4'd0) begin
          hnz0_nxt = 1'b1;
          ffln_nxt = fc0_r + 1'b1;
        end
        fc0_nxt = fc0_r + 1'b1;
      end
    end

    if (s1_valid_r && s1_r.last) begin
      if (!on_second_r) begin
        on_second_nxt = 1'b1;
        phase_nxt     = dsc_pkg::PH_BLANK;
      end else begin
        s2_nxt.res       = 1'b1;
        s2_nxt.both_zero = !hnz0_nxt && !hnz1_nxt;
        s2_nxt.sign0     = sign0_nxt;
        s2_nxt.sign1     = sign1_nxt;
        s2_nxt.cnt_cmp   = (ic0_nxt < ic1_nxt) ? dsc_pkg::ORD_LESS :
                           (ic0_nxt > ic1_nxt) ? dsc_pkg::ORD_GREATER : dsc_pkg::ORD_EQUAL;
        s2_nxt.tail_gt   = ffln_nxt > fc1_nxt;
        s2_nxt.ovf       = ovf_nxt;
        phase_nxt        = dsc_pkg::PH_BLANK;
        on_second_nxt    = 1'b0;
        sign0_nxt        = 1'b0;
        sign1_nxt        = 1'b0;
        hnz0_nxt         = 1'b0;
        hnz1_nxt         = 1'b0;
        ic0_nxt          = '0;
        ic1_nxt          = '0;
        fc0_nxt          = '0;
        fc1_nxt          = '0;
        ffln_nxt         = '0;
        ovf_nxt          = 1'b0;
      end
    end
  end

  assign frac_a = s2_r.frac_in_range ? rd_frac_r : 4'd0;

  always_comb begin
    int_diff_nxt  = int_diff_r;
    frac_diff_nxt = frac_diff_r;
    if (s2_valid_r && s2_r.cmp_int && int_diff_r == dsc_pkg::ORD_EQUAL &&
        rd_int_r != s2_r.digit) begin
      int_diff_nxt = (rd_int_r < s2_r.digit) ? dsc_pkg::ORD_LESS : dsc_pkg::ORD_GREATER;
    end
    if (s2_valid_r && s2_r.cmp_frac && frac_diff_r == dsc_pkg::ORD_EQUAL &&
        frac_a != s2_r.digit) begin
      frac_diff_nxt = (frac_a < s2_r.digit) ? dsc_pkg::ORD_LESS : dsc_pkg::ORD_GREATER;
    end

    if (s2_r.cnt_cmp != dsc_pkg::ORD_EQUAL) begin
      mag = s2_r.cnt_cmp;
    end else if (int_diff_nxt != dsc_pkg::ORD_EQUAL) begin
      mag = int_diff_nxt;
    end else if (frac_diff_nxt != dsc_pkg::ORD_EQUAL) begin
      mag = frac_diff_nxt;
    end else if (s2_r.tail_gt) begin
      mag = dsc_pkg::ORD_GREATER;
    end else begin
      mag = dsc_pkg::ORD_EQUAL;
    end

    if (s2_r.both_zero) begin
      order = dsc_pkg::ORD_EQUAL;
    end else if (s2_r.sign0 != s2_r.sign1) begin
      order = s2_r.sign0 ? dsc_pkg::ORD_LESS : dsc_pkg::ORD_GREATER;
    end else if (s2_r.sign0) begin
      order = dsc_pkg::ORD_EQUAL - mag;
    end else begin
      order = mag;
    end

    out_nxt.order    = order;
    out_nxt.overflow = s2_r.ovf;
  end

  always_ff @(posedge clk) begin
    if (adv && wr_int) begin
      int_mem[int_addr] <= d;
    end
    if (adv && wr_frac) begin
      frac_mem[frac_addr] <= d;
    end
    if (adv) begin
      rd_int_r  <= int_mem[int_addr];
      rd_frac_r <= frac_mem[frac_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_data;
      s2_r <= s2_nxt;
    end
    if (adv && s2_valid_r && s2_r.res) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= dsc_pkg::PH_BLANK;
      on_second_r <= 1'b0;
      sign0_r     <= 1'b0;
      sign1_r     <= 1'b0;
      hnz0_r      <= 1'b0;
      hnz1_r      <= 1'b0;
      ic0_r       <= '0;
      ic1_r       <= '0;
      fc0_r       <= '0;
      fc1_r       <= '0;
      ffln_r      <= '0;
      ovf_r       <= 1'b0;
      int_diff_r  <= dsc_pkg::ORD_EQUAL;
      frac_diff_r <= dsc_pkg::ORD_EQUAL;
    end else begin
      if (adv) begin
        s1_valid_r  <= in_valid;
        s2_valid_r  <= s1_valid_r;
        phase_r     <= phase_nxt;
        on_second_r <= on_second_nxt;
        sign0_r     <= sign0_nxt;
        sign1_r     <= sign1_nxt;
        hnz0_r      <= hnz0_nxt;
        hnz1_r      <= hnz1_nxt;
        ic0_r       <= ic0_nxt;
        ic1_r       <= ic1_nxt;
        fc0_r       <= fc0_nxt;
        fc1_r       <= fc1_nxt;
        ffln_r      <= ffln_nxt;
        ovf_r       <= ovf_nxt;
        if (s2_valid_r && s2_r.res) begin
          int_diff_r  <= dsc_pkg::ORD_EQUAL;
          frac_diff_r <= dsc_pkg::ORD_EQUAL;
        end else begin
          int_diff_r  <= int_diff_nxt;
          frac_diff_r <= frac_diff_nxt;
        end
      end
      if (adv && s2_valid_r && s2_r.res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
